// ===== sv/tls_client_hello_parser_defines.svh =====
// Assertion macros for the ClientHello parser.
`ifndef TLS_CLIENT_HELLO_PARSER_DEFINES_SVH
`define TLS_CLIENT_HELLO_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tls_chp_pkg.sv =====
// Shared types and constants of the ClientHello parser.
`default_nettype none
package tls_chp_pkg;

   // Parse phases; the values below the done phase double as field codes
   typedef enum logic [3:0] {
      PH_TYPE    = 4'd0,
      PH_LEN     = 4'd1,
      PH_VER     = 4'd2,
      PH_RAND    = 4'd3,
      PH_SIDLEN  = 4'd4,
      PH_SID     = 4'd5,
      PH_CSLEN   = 4'd6,
      PH_SUITE   = 4'd7,
      PH_COMPLEN = 4'd8,
      PH_COMP    = 4'd9,
      PH_EXTLEN  = 4'd10,
      PH_EXTHDR  = 4'd11,
      PH_EXTBODY = 4'd12,
      PH_IGN     = 4'd13,
      PH_DONE    = 4'd14
   } phase_type;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_MAX_SID = 2'd0;
   localparam logic [1:0] CSR_MAX_CS  = 2'd1;
   localparam logic [1:0] CSR_MAX_EXT = 2'd2;

   localparam logic [7:0]  MAX_SID_RESET = 8'd32;
   localparam logic [15:0] MAX_CS_RESET  = 16'd256;
   localparam logic [14:0] MAX_EXT_RESET = 15'd8192;

   // Warning bit positions
   localparam int W_SID      = 0;
   localparam int W_CIPHERS  = 1;
   localparam int W_COMP     = 2;
   localparam int W_EXT_SIZE = 3;
   localparam int W_OVERRUN  = 4;
   localparam int W_EXT_RES  = 5;
   localparam int W_LEN_RES  = 6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_start;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  field_code;
      logic [15:0] field_offset;
      logic        message_last;
      logic [6:0]  warning_bits;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  max_session_id_len;
      logic [15:0] max_cipher_list_len;
      logic [14:0] max_extensions_len;
   } cfg_type;

   // Parser state carried from byte to byte; budget is two's complement
   typedef struct packed {
      phase_type   phase;
      logic [15:0] field_counter;
      logic [23:0] message_remaining;
      logic [7:0]  session_id_count;
      logic [15:0] cipher_list_count;
      logic [7:0]  compression_count;
      logic [16:0] extensions_budget;
      logic [15:0] extension_remaining;
      logic [15:0] length_assembly;
      logic [6:0]  warning_flags;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:               PH_TYPE,
      field_counter:       16'd0,
      message_remaining:   24'd0,
      session_id_count:    8'd0,
      cipher_list_count:   16'd0,
      compression_count:   8'd0,
      extensions_budget:   17'd0,
      extension_remaining: 16'd0,
      length_assembly:     16'd0,
      warning_flags:       7'd0
   };

endpackage
`default_nettype wire

// ===== sv/tls_chp_csr.sv =====
// Configuration registers of the ClientHello parser.
`default_nettype none
module tls_chp_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wen,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   output tls_chp_pkg::cfg_type    cfg
);

   tls_chp_pkg::cfg_type cfg_ff, cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            tls_chp_pkg::CSR_MAX_SID: cfg_in.max_session_id_len  = csr_wdata[7:0];
            tls_chp_pkg::CSR_MAX_CS:  cfg_in.max_cipher_list_len = csr_wdata;
            tls_chp_pkg::CSR_MAX_EXT: cfg_in.max_extensions_len  = csr_wdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_session_id_len  <= tls_chp_pkg::MAX_SID_RESET;
         cfg_ff.max_cipher_list_len <= tls_chp_pkg::MAX_CS_RESET;
         cfg_ff.max_extensions_len  <= tls_chp_pkg::MAX_EXT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== sv/tls_chp_step.sv =====
// Per-byte tagging logic: current state and byte in, next state and result out.
`default_nettype none
module tls_chp_step (
   input  wire tls_chp_pkg::parse_state_type cur_state,
   input  wire tls_chp_pkg::req_payload_type request,
   input  wire tls_chp_pkg::cfg_type         cfg,
   output tls_chp_pkg::parse_state_type      nxt_state,
   output tls_chp_pkg::rsp_payload_type      result
);

   tls_chp_pkg::parse_state_type st;
   logic [7:0]  b;
   logic [15:0] off;
   logic [15:0] off_inc;
   logic [15:0] v;
   logic [17:0] diff;
   logic [23:0] mr_dec;
   logic [7:0]  sid_dec;
   logic [15:0] cs_dec;
   logic [7:0]  comp_dec;
   logic [15:0] er_dec;
   logic        boundary;
   logic        body;
   logic        last;

   // Start of message wipes the state before the byte is taken
   assign st  = request.message_start ? tls_chp_pkg::STATE_CLEAR : cur_state;
   assign b   = request.data_byte;
   assign off = st.field_counter;
   assign v   = {st.length_assembly[7:0], b};

   assign off_inc  = (off != 16'hFFFF) ? off + 16'd1 : off;
   assign mr_dec   = (st.message_remaining != 24'd0) ? st.message_remaining - 24'd1 : 24'd0;
   assign sid_dec  = (st.session_id_count != 8'd0) ? st.session_id_count - 8'd1 : 8'd0;
   assign cs_dec   = (st.cipher_list_count != 16'd0) ? st.cipher_list_count - 16'd1 : 16'd0;
   assign comp_dec = (st.compression_count != 8'd0) ? st.compression_count - 8'd1 : 8'd0;
   assign er_dec   = (st.extension_remaining != 16'd0) ?
                     st.extension_remaining - 16'd1 : 16'd0;
   // Budget minus body length minus the four header bytes
   assign diff = {st.extensions_budget[16], st.extensions_budget} - {2'b00, v} - 18'd4;

   // Phase handling and message end
   always_comb begin
      nxt_state = st;
      nxt_state.field_counter = off_inc;
      boundary = 1'b0;
      body = 1'b1;
      last = 1'b0;
      case (st.phase)
         tls_chp_pkg::PH_TYPE: begin
            body = 1'b0;
            nxt_state.phase = tls_chp_pkg::PH_LEN;
            nxt_state.field_counter = 16'd0;
         end
         tls_chp_pkg::PH_LEN: begin
            body = 1'b0;
            if (off < 16'd2) begin
               nxt_state.length_assembly = {st.length_assembly[7:0], b};
            end else begin
               nxt_state.message_remaining = {st.length_assembly, b};
               nxt_state.field_counter = 16'd0;
               if ({st.length_assembly, b} == 24'd0) begin
                  last = 1'b1;
                  nxt_state.warning_flags[tls_chp_pkg::W_LEN_RES] = 1'b1;
                  nxt_state.phase = tls_chp_pkg::PH_DONE;
               end else begin
                  nxt_state.phase = tls_chp_pkg::PH_VER;
               end
            end
         end
         tls_chp_pkg::PH_VER: begin
            if (off >= 16'd1) begin
               nxt_state.phase = tls_chp_pkg::PH_RAND;
               nxt_state.field_counter = 16'd0;
            end
         end
         tls_chp_pkg::PH_RAND: begin
            if (off >= 16'd31) begin
               nxt_state.phase = tls_chp_pkg::PH_SIDLEN;
               nxt_state.field_counter = 16'd0;
            end
         end
         tls_chp_pkg::PH_SIDLEN: begin
            nxt_state.session_id_count = b;
            if (b > cfg.max_session_id_len) nxt_state.warning_flags[tls_chp_pkg::W_SID] = 1'b1;
            nxt_state.phase = (b != 8'd0) ? tls_chp_pkg::PH_SID : tls_chp_pkg::PH_CSLEN;
            nxt_state.field_counter = 16'd0;
         end
         tls_chp_pkg::PH_SID: begin
            nxt_state.session_id_count = sid_dec;
            if (sid_dec == 8'd0) begin
               nxt_state.phase = tls_chp_pkg::PH_CSLEN;
               nxt_state.field_counter = 16'd0;
            end
         end
         tls_chp_pkg::PH_CSLEN: begin
            if (off == 16'd0) begin
               nxt_state.length_assembly = {8'd0, b};
            end else begin
               if (v > cfg.max_cipher_list_len)
                  nxt_state.warning_flags[tls_chp_pkg::W_CIPHERS] = 1'b1;
               // odd lengths drop the trailing byte
               nxt_state.cipher_list_count = {v[15:1], 1'b0};
               nxt_state.phase = (v[15:1] != 15'd0) ?
                                 tls_chp_pkg::PH_SUITE : tls_chp_pkg::PH_COMPLEN;
               nxt_state.field_counter = 16'd0;
            end
         end
         tls_chp_pkg::PH_SUITE: begin
            nxt_state.cipher_list_count = cs_dec;
            if (cs_dec == 16'd0) begin
               nxt_state.phase = tls_chp_pkg::PH_COMPLEN;
               nxt_state.field_counter = 16'd0;
            end
         end
         tls_chp_pkg::PH_COMPLEN: begin
            nxt_state.compression_count = b;
            if (b > 8'd1) nxt_state.warning_flags[tls_chp_pkg::W_COMP] = 1'b1;
            nxt_state.phase = (b != 8'd0) ? tls_chp_pkg::PH_COMP : tls_chp_pkg::PH_EXTLEN;
            nxt_state.field_counter = 16'd0;
         end
         tls_chp_pkg::PH_COMP: begin
            nxt_state.compression_count = comp_dec;
            if (comp_dec == 8'd0) begin
               nxt_state.phase = tls_chp_pkg::PH_EXTLEN;
               nxt_state.field_counter = 16'd0;
            end
         end
         tls_chp_pkg::PH_EXTLEN: begin
            if (off == 16'd0) begin
               nxt_state.length_assembly = {8'd0, b};
            end else begin
               // signed 16-bit length, sign extended into the budget
               nxt_state.extensions_budget = {v[15], v};
               if (!v[15] && (v[14:0] > cfg.max_extensions_len))
                  nxt_state.warning_flags[tls_chp_pkg::W_EXT_SIZE] = 1'b1;
               nxt_state.phase = tls_chp_pkg::PH_EXTHDR;
               nxt_state.field_counter = 16'd0;
               boundary = 1'b1;
            end
         end
         tls_chp_pkg::PH_EXTHDR: begin
            if (off == 16'd2) begin
               nxt_state.length_assembly = {8'd0, b};
            end else if (off >= 16'd3) begin
               nxt_state.extension_remaining = v;
               // saturate at -65536
               if (diff[17:16] == 2'b10) nxt_state.extensions_budget = 17'h10000;
               else nxt_state.extensions_budget = diff[16:0];
               boundary = (v == 16'd0);
               nxt_state.field_counter = 16'd0;
               if (diff[17]) nxt_state.phase = tls_chp_pkg::PH_IGN;
               else if (v != 16'd0) nxt_state.phase = tls_chp_pkg::PH_EXTBODY;
               else nxt_state.phase = tls_chp_pkg::PH_EXTHDR;
            end
         end
         tls_chp_pkg::PH_EXTBODY: begin
            nxt_state.extension_remaining = er_dec;
            if (er_dec == 16'd0) begin
               nxt_state.phase = tls_chp_pkg::PH_EXTHDR;
               nxt_state.field_counter = 16'd0;
               boundary = 1'b1;
            end
         end
         tls_chp_pkg::PH_IGN: begin
            // still counts down the body that overdrew the budget
            if (st.extension_remaining != 16'd0) begin
               nxt_state.extension_remaining = er_dec;
               boundary = (er_dec == 16'd0);
            end
         end
         default: begin
            // past the declared end: overrun
            body = 1'b0;
            nxt_state.warning_flags[tls_chp_pkg::W_OVERRUN] = 1'b1;
            nxt_state.phase = tls_chp_pkg::PH_DONE;
         end
      endcase

      // Message end on a body byte
      if (body) begin
         nxt_state.message_remaining = mr_dec;
         if (mr_dec == 24'd0) begin
            last = 1'b1;
            if (nxt_state.extensions_budget != 17'd0)
               nxt_state.warning_flags[tls_chp_pkg::W_EXT_RES] = 1'b1;
            if (!boundary) nxt_state.warning_flags[tls_chp_pkg::W_LEN_RES] = 1'b1;
            nxt_state.phase = tls_chp_pkg::PH_DONE;
            nxt_state.field_counter = 16'd0;
         end
      end
   end

   // Result for this byte
   always_comb begin
      result.field_code   = (st.phase == tls_chp_pkg::PH_DONE) ?
                            tls_chp_pkg::PH_IGN : st.phase;
      result.field_offset = off;
      result.message_last = last;
      result.warning_bits = nxt_state.warning_flags;
   end

endmodule
`default_nettype wire

// ===== sv/tls_client_hello_parser.sv =====
// Top level of the ClientHello byte tagger: request register, parser state, result register.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall req_payload (data_byte, message_start)
//   rsp_      out        rsp_valid/rsp_stall rsp_payload (code, offset, last, warnings)
//   csr_      in         csr_wen             csr_index, csr_wdata
//
// One request per cycle unless rsp_stall backs up; each result waits in the result register.
// The state update for a byte happens as it moves from the request register to the
// result register, one short step of counter and phase logic.
// A stalled result holds the request register; req_stall rises only when both are full.
// Synchronous reset clears the state to the type phase and loads register defaults.
`default_nettype none
`include "tls_client_hello_parser_defines.svh"
module tls_client_hello_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tls_chp_pkg::req_payload_type    req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tls_chp_pkg::rsp_payload_type         rsp_payload,
   input  wire logic                            csr_wen,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [15:0]                     csr_wdata
);

   tls_chp_pkg::cfg_type          cfg;
   tls_chp_pkg::req_payload_type  in_ff;
   logic                          in_valid_ff, in_valid_in;
   tls_chp_pkg::parse_state_type  state_ff, state_in;
   tls_chp_pkg::rsp_payload_type  out_ff, result;
   logic                          out_valid_ff, out_valid_in;
   logic                          advance;

   tls_chp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tls_chp_step u_step (
      .cur_state (state_ff),
      .request   (in_ff),
      .cfg       (cfg),
      .nxt_state (state_in),
      .result    (result)
   );

   // Handshake: the request stage moves on whenever the result stage is free or not stalled
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= tls_chp_pkg::STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_ff <= req_payload;
      if (advance) out_ff <= result;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // Checks
   `TCHP_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall,
      in_valid_ff && out_valid_ff && rsp_stall, "request stall without both stages full")
   `TCHP_ASSERT_NEXT(a_held_request_kept, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_ff), "held request lost or changed")
   `TCHP_ASSERT_NEXT(a_done_after_last, clock, reset, advance && result.message_last,
      state_ff.phase == tls_chp_pkg::PH_DONE, "parser not done after message end")
   `TCHP_ASSERT_NEXT(a_warnings_sticky, clock, reset,
      advance && !in_ff.message_start,
      (state_ff.warning_flags & $past(state_ff.warning_flags)) ==
      $past(state_ff.warning_flags), "warning cleared within a message")

endmodule
`default_nettype wire
